>>> rtl/maximal_square_of_ones_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the maximal square block
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MAXIMAL_SQUARE_OF_ONES_ASSERT_SVH
`define MAXIMAL_SQUARE_OF_ONES_ASSERT_SVH

// same-cycle implication
`define MSQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("maximal square check failed");

// next-cycle implication
`define MSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("maximal square check failed");

`endif

>>> rtl/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg
// Widths, sizes and the cell word type shared by the maximal square block.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

    localparam int MAX_COLS = 256;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int LEN_W    = 9;
    localparam int EFF_W    = (LEN_W > COL_W + 1) ? LEN_W : COL_W + 1;
    localparam int SIDE_W   = 9;
    localparam int AREA_W   = 17;
    localparam int PROD_W   = 2 * SIDE_W;

    localparam logic [LEN_W-1:0] ROW_LENGTH_RST = LEN_W'(256);

    typedef struct packed {
        logic             cell_bit;
        logic             last_cell;
        logic             first_row;
        logic [COL_W-1:0] col;
    } t_cell;

endpackage

`default_nettype wire

>>> rtl/msq_ram.sv
// ----------------------------------------------------------------------------
// msq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/msq_colseq.sv
// ----------------------------------------------------------------------------
// msq_colseq
// Column sequencer: tracks column and first-row flag of each incoming word.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_colseq
    import msq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [LEN_W-1:0] i_row_length,
    input  wire logic             i_acc,
    input  wire logic             i_cell_bit,
    input  wire logic             i_last_cell,
    output t_cell                 o_cell
);

    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic             r_first;
    logic             n_first;
    logic [EFF_W-1:0] len_eff;
    logic [EFF_W-1:0] col_inc;
    logic             wrap_now;
    logic [COL_W-1:0] col_cur;
    logic             first_cur;

    always_comb begin
        priority if (i_row_length == '0) begin
            len_eff = EFF_W'(1);
        end else if (EFF_W'(i_row_length) > EFF_W'(MAX_COLS)) begin
            len_eff = EFF_W'(MAX_COLS);
        end else begin
            len_eff = EFF_W'(i_row_length);
        end
    end

    // wrap late when the length shrank under the current column
    assign wrap_now  = EFF_W'(r_col) >= len_eff;
    assign col_cur   = wrap_now ? '0   : r_col;
    assign first_cur = wrap_now ? 1'b0 : r_first;
    assign col_inc   = EFF_W'(col_cur) + EFF_W'(1);

    always_comb begin
        priority if (i_last_cell) begin
            n_col   = '0;
            n_first = 1'b1;
        end else if (col_inc >= len_eff) begin
            n_col   = '0;
            n_first = 1'b0;
        end else begin
            n_col   = col_inc[COL_W-1:0];
            n_first = first_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else if (i_acc) begin
            r_col   <= n_col;
            r_first <= n_first;
        end
    end

    assign o_cell = '{cell_bit:  i_cell_bit,
                      last_cell: i_last_cell,
                      first_row: first_cur,
                      col:       col_cur};

endmodule

`default_nettype wire

>>> rtl/maximal_square_of_ones.sv
// Stage 1 holds each accepted cell; the result word is registered onto o_valid as the last
// cell leaves it. Throughput: one cell per cycle unless a stalled result holds stage 1.
// Same-column read after write is forwarded, so any row length runs at full rate.
// Reset clears control, sides, best and row length (256); the row memory is not cleared.
// ----------------------------------------------------------------------------
// maximal_square_of_ones
// Streams binary matrix cells in raster order and reports the largest all-ones
// square (area and side) on the cell flagged last.
// ----------------------------------------------------------------------------
`default_nettype none
`include "maximal_square_of_ones_assert.svh"

module maximal_square_of_ones
    import msq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [LEN_W-1:0]  i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_cell_bit,
    input  wire logic              i_last_cell,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [AREA_W-1:0] o_max_area,
    output logic      [SIDE_W-1:0] o_max_side
);

    logic [LEN_W-1:0]  r_row_length;
    t_cell             cell0;
    logic              acc;
    logic              advance;
    logic              fire1;

    logic              r_v1;
    t_cell             r_s1;
    logic              r_fwd;
    logic [SIDE_W-1:0] r_fwd_val;
    logic [SIDE_W-1:0] r_left;
    logic [SIDE_W-1:0] r_diag;
    logic [SIDE_W-1:0] r_best;
    logic              r_out_v;
    logic [SIDE_W-1:0] r_out_side;

    logic [SIDE_W-1:0] ram_rdata;
    logic [SIDE_W-1:0] up;
    logic [SIDE_W-1:0] left;
    logic [SIDE_W-1:0] diag;
    logic [SIDE_W-1:0] m_ul;
    logic [SIDE_W-1:0] m_all;
    logic [SIDE_W-1:0] side_nx;
    logic [SIDE_W-1:0] best_nx;
    logic [PROD_W-1:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_row_length <= i_cfg_wdata;
        end
    end

    // stage 1 drains unless its result word has nowhere to go
    assign fire1   = r_v1 && (!r_s1.last_cell || !r_out_v || !i_stall);
    assign advance = !r_v1 || fire1;
    assign o_stall = !advance;
    assign acc     = i_valid && advance;

    msq_colseq u_colseq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_row_length (r_row_length),
        .i_acc        (acc),
        .i_cell_bit   (i_cell_bit),
        .i_last_cell  (i_last_cell),
        .o_cell       (cell0)
    );

    msq_ram #(
        .WIDTH (SIDE_W),
        .DEPTH (MAX_COLS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (fire1),
        .i_waddr (r_s1.col),
        .i_wdata (side_nx),
        .i_re    (acc),
        .i_raddr (cell0.col),
        .o_rdata (ram_rdata)
    );

    assign up   = r_s1.first_row ? '0 : (r_fwd ? r_fwd_val : ram_rdata);
    assign left = (r_s1.col == '0) ? '0 : r_left;
    assign diag = (r_s1.col == '0 || r_s1.first_row) ? '0 : r_diag;

    always_comb begin
        m_ul    = (up < left) ? up : left;
        m_all   = (m_ul < diag) ? m_ul : diag;
        side_nx = r_s1.cell_bit ? m_all + SIDE_W'(1) : '0;
        best_nx = (side_nx > r_best) ? side_nx : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (advance) begin
            r_v1 <= acc;
        end
    end

    // hold the word and forward a write that lands on the column just read
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1      <= cell0;
            r_fwd     <= fire1 && (r_s1.col == cell0.col);
            r_fwd_val <= side_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_diag <= '0;
            r_best <= '0;
        end else if (fire1) begin
            r_left <= side_nx;
            r_diag <= up;
            r_best <= r_s1.last_cell ? '0 : best_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (fire1 && r_s1.last_cell) begin
            r_out_v <= 1'b1;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire1 && r_s1.last_cell) begin
            r_out_side <= best_nx;
        end
    end

    assign prod       = PROD_W'(r_out_side) * PROD_W'(r_out_side);
    assign o_valid    = r_out_v;
    assign o_max_side = r_out_side;
    assign o_max_area = prod[AREA_W-1:0];

    `MSQ_ASSERT_NEXT(a_last_gives_word, fire1 && r_s1.last_cell, o_valid)
    `MSQ_ASSERT_NEXT(a_best_monotone, fire1 && !r_s1.last_cell, r_best >= $past(r_best))
    `MSQ_ASSERT_SAME(a_side_bounded, r_v1, side_nx <= SIDE_W'(r_s1.col) + SIDE_W'(1))
    `MSQ_ASSERT_SAME(a_first_row_side, r_v1 && r_s1.first_row, side_nx <= SIDE_W'(1))

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maximal square of ones testbench
// Streams binary matrices through the block in raster order, with random idle
// and stall on both sides. Each accepted cell goes into a scoreboard model that
// tracks the row of square sides and the best square. Each result word is
// checked, area and side, against the oldest expected word. Row length is
// changed between and inside matrices, including zero and values over the
// buffer size.
// ----------------------------------------------------------------------------

import msq_pkg::*;

typedef struct {
    logic [AREA_W-1:0] area;
    logic [SIDE_W-1:0] side;
} t_square;

class square_scoreboard;
    logic [SIDE_W-1:0] side_row [MAX_COLS];
    logic [SIDE_W-1:0] left_run;
    logic [SIDE_W-1:0] diag_run;
    logic [SIDE_W-1:0] best_run;
    int unsigned       col_pos;
    bit                on_top_row;
    logic [LEN_W-1:0]  cols_cfg;
    t_square           square_q[$];
    int unsigned       errors;

    function new();
        foreach (side_row[i]) side_row[i] = '0;
        cols_cfg = ROW_LENGTH_RST;
        errors   = 0;
        restart();
    endfunction

    function void restart();
        left_run   = '0;
        diag_run   = '0;
        best_run   = '0;
        col_pos    = 0;
        on_top_row = 1'b1;
    endfunction

    function void set_row_length(logic [LEN_W-1:0] value);
        cols_cfg = value;
    endfunction

    function int unsigned row_cols();
        if (cols_cfg == 0) return 1;
        if (cols_cfg > MAX_COLS) return MAX_COLS;
        return 32'(cols_cfg);
    endfunction

    function int unsigned pending();
        return square_q.size();
    endfunction

    function void note_cell(bit cell_v, bit is_last);
        int unsigned       cols;
        int unsigned       sq;
        logic [SIDE_W-1:0] up;
        logic [SIDE_W-1:0] lf;
        logic [SIDE_W-1:0] dg;
        logic [SIDE_W-1:0] low;
        logic [SIDE_W-1:0] side;
        t_square           res;
        cols = row_cols();
        if (col_pos >= cols) begin
            col_pos    = 0;
            on_top_row = 1'b0;
        end
        up  = on_top_row ? '0 : side_row[col_pos[COL_W-1:0]];
        lf  = (col_pos == 0) ? '0 : left_run;
        dg  = (col_pos == 0 || on_top_row) ? '0 : diag_run;
        low = (up < lf) ? up : lf;
        if (dg < low) low = dg;
        side = cell_v ? low + 1'b1 : '0;
        side_row[col_pos[COL_W-1:0]] = side;
        diag_run = up;
        left_run = side;
        if (side > best_run) best_run = side;
        if (is_last) begin
            sq       = 32'(best_run);
            sq       = sq * sq;
            res.area = sq[AREA_W-1:0];
            res.side = best_run;
            square_q.push_back(res);
            restart();
        end else begin
            col_pos++;
            if (col_pos >= cols) begin
                col_pos    = 0;
                on_top_row = 1'b0;
            end
        end
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [AREA_W-1:0] area, logic [SIDE_W-1:0] side);
        t_square want;
        if (square_q.size() == 0) begin
            flag("result word with none expected, area", 0, 32'(area));
            return;
        end
        want = square_q.pop_front();
        if (area !== want.area) flag("max_area mismatch", 32'(want.area), 32'(area));
        if (side !== want.side) flag("max_side mismatch", 32'(want.side), 32'(side));
    endfunction
endclass

module testbench;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [LEN_W-1:0]  i_cfg_wdata = '0;
    logic              i_valid     = 1'b0;
    logic              i_cell_bit  = 1'b0;
    logic              i_last_cell = 1'b0;
    logic              i_stall     = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [AREA_W-1:0] o_max_area;
    logic [SIDE_W-1:0] o_max_side;

    square_scoreboard sb = new();
    bit               idle_on = 1'b1;
    int unsigned      cells_sent;

    maximal_square_of_ones u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cell_bit  (i_cell_bit),
        .i_last_cell (i_last_cell),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_max_area  (o_max_area),
        .o_max_side  (o_max_side)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) sb.check_result(o_max_area, o_max_side);
            i_stall <= idle_on && ($urandom_range(99) < 23);
        end
    end

    task automatic send_cell(input bit cell_v, input bit is_last);
        while (idle_on && $urandom_range(99) < 23) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cell_bit  <= cell_v;
        i_last_cell <= is_last;
        do @(posedge i_clk); while (o_stall);
        sb.note_cell(cell_v, is_last);
        cells_sent++;
    endtask

    task automatic send_cells(input int unsigned count, input int unsigned pct_ones,
                              input bit close);
        for (int unsigned k = 1; k <= count; k++)
            send_cell($urandom_range(99) < pct_ones, close && k == count);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_row_length(value);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return LEN_W'($urandom_range(1, 12));
        if (r < 68) return '0;
        if (r < 76) return LEN_W'(256);
        if (r < 82) return '1;
        if (r < 90) return LEN_W'($urandom_range(257, 510));
        return LEN_W'($urandom_range(13, 255));
    endfunction

    function automatic int unsigned pick_density();
        case ($urandom_range(4))
            0: return 0;
            1: return 30;
            2: return 70;
            3: return 90;
            default: return 100;
        endcase
    endfunction

    initial begin
        int unsigned cols;
        int unsigned total;
        int unsigned split;
        int unsigned pct;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole row buffer at the reset length, then wrap into a second row
        send_cells(258, 100, 1'b0);
        send_cell(1'b1, 1'b1);

        write_length('0);
        send_cells(4, 100, 1'b1);
        write_length(LEN_W'(3));
        send_cells(9, 100, 1'b1);
        send_cell(1'b0, 1'b1);
        // shrink mid-matrix so the next word starts a new row
        send_cells(4, 100, 1'b0);
        write_length(LEN_W'(1));
        send_cells(2, 100, 1'b1);
        write_length('1);
        send_cells(5, 100, 1'b1);

        while (cells_sent < 950) begin
            idle_on = !(cells_sent >= 400 && cells_sent < 600);
            if ($urandom_range(3) == 0) write_length(pick_length());
            cols = sb.row_cols();
            if (cols <= 12)
                total = cols * $urandom_range(1, 8) +
                        (($urandom_range(3) == 0) ? $urandom_range(0, cols - 1) : 0);
            else
                total = $urandom_range(1, 40);
            pct = pick_density();
            if (total > 1 && $urandom_range(9) == 0) begin
                split = $urandom_range(1, total - 1);
                send_cells(split, pct, 1'b0);
                write_length(pick_length());
                send_cells(total - split, pct, 1'b1);
            end else begin
                send_cells(total, pct, 1'b1);
            end
        end
        idle_on = 1'b1;

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
